>>> src/lsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line scramble permutation package
// Shared codes, widths, reset values and types of the permutation generator.
// ----------------------------------------------------------------------------
package lsp_pkg;

    localparam int OP_W       = 2;
    localparam int POS_W      = 10;
    localparam int ROW_W      = 10;
    localparam int LINE_CNT_W = 11;
    localparam int GEN_W      = 16;
    localparam int SKIP_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_START  = 2'd0;
    localparam logic [OP_W-1:0] OP_PLACE  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_SECOND = 2'd2;

    localparam logic [LINE_CNT_W-1:0] LINE_COUNT_RST  = 11'd1024;
    localparam logic [GEN_W-1:0]      SEED_FIRST_RST  = 16'h4444;
    localparam logic [GEN_W-1:0]      SEED_SECOND_RST = 16'h8888;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_WALK,
        S_PLACE,
        S_LOOK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [POS_W-1:0] placed_position;
        logic [ROW_W-1:0] row_value;
        logic             table_full;
        logic             last_row;
    } t_res;

endpackage

>>> src/lsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line scramble permutation channels
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface lsp_in_if import lsp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] lookup_position;

    modport source (output valid, output op, output lookup_position, input ready);
    modport sink   (input valid, input op, input lookup_position, output ready);
endinterface

interface lsp_out_if import lsp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] placed_position;
    logic [ROW_W-1:0] row_value;
    logic             table_full;
    logic             last_row;

    modport source (output valid, output placed_position, output row_value,
                    output table_full, output last_row, input ready);
    modport sink   (input valid, input placed_position, input row_value,
                    input table_full, input last_row, output ready);
endinterface

interface lsp_cfg_if import lsp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/lsp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line scramble permutation RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module lsp_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/lsp_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line scramble permutation remainder unit
// Restoring remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module lsp_mod_unit #(
    parameter int CW = 11,
    parameter int PW = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [CW-1:0] i_dividend,
    input  logic [CW-1:0] i_divisor,
    output logic          o_done,
    output logic [PW-1:0] o_rem
);

    localparam int CNT_W = $clog2(CW + 1);

    logic [CW-1:0]    r_rem;
    logic [CW-1:0]    r_dvd;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [CW:0] trial;
    logic [CW:0] diff;
    logic        ge;
    logic [CW-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[CW-1]};
        diff  = trial - {1'b0, i_divisor};
        ge    = (trial >= {1'b0, i_divisor});
        n_rem = ge ? diff[CW-1:0] : trial[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(CW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[CW-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // The remainder is below the divisor, which never exceeds the table depth.
    assign o_done = r_done;
    assign o_rem  = PW'(r_rem);

endmodule

>>> src/line_scramble_permutation_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line scramble permutation generator
// Builds the line permutation one row per place request.
// ----------------------------------------------------------------------------
// Channels: i_in carries requests (start, place, lookup), o_out returns exactly
// one result per request, i_cfg writes line_count and the two seed words and
// is always ready; write it only while the block is idle.
// A place request probes the taken map until the skip count of free
// positions is reached (one probe per cycle from the single read port of the
// taken map). The walk passes up to 255 free positions plus every taken one
// on the way, so with one position left free it can circle the line count up
// to 255 times. When the cursor sits on or past the last line, the first
// step goes through the remainder unit. A lookup goes through the row table;
// a full-table place or an unknown op goes straight to the result. A start
// request sweeps the taken map, one entry per cycle, and answers once the
// sweep is done. After reset the same sweep runs before the first request
// is taken. One request is worked on at a time; a finished result sits in
// the output register, so a stalled receiver only holds back the next
// result, and the block takes the next request meanwhile.
// ----------------------------------------------------------------------------
module line_scramble_permutation_generator_top
    import lsp_pkg::*;
#(
    parameter int MAX_LINES = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lsp_cfg_if.sink      i_cfg,
    lsp_in_if.sink       i_in,
    lsp_out_if.source    o_out
);

    localparam int PW = $clog2(MAX_LINES);
    localparam int CW = $clog2(MAX_LINES + 1);

    t_state r_state, n_state;

    logic [LINE_CNT_W-1:0] r_line_count;
    logic [GEN_W-1:0]      r_seed_first;
    logic [GEN_W-1:0]      r_seed_second;
    logic [GEN_W-1:0]      r_gen_first;
    logic [GEN_W-1:0]      r_gen_second;
    logic [PW-1:0]         r_cursor;
    logic [CW-1:0]         r_next_row;

    logic [PW-1:0]     r_clr_addr;
    logic              r_emit_clr;
    logic [PW-1:0]     r_walk_addr;
    logic [PW-1:0]     r_probe_addr;
    logic              r_probe_vld;
    logic [SKIP_W-1:0] r_skip;
    logic [PW-1:0]     r_place_pos;
    logic              r_lk_ok;
    t_res              r_res;
    t_res              r_o_res;
    logic              r_o_valid;

    logic [CW-1:0]     n_lines;
    logic [CW-1:0]     cur1;
    logic              in_acc;
    logic              out_free;
    logic              is_full;
    logic              clr_last;
    logic              probe_free;
    logic              probe_hit;
    logic [PW-1:0]     walk_inc;
    logic [GEN_W-1:0]  gen_sum;
    logic [GEN_W-1:0]  gen_swap;
    logic [SKIP_W-1:0] skip_init;
    logic              lk_in_range;

    logic          tk_we;
    logic [PW-1:0] tk_waddr;
    logic          tk_wdata;
    logic          tk_re;
    logic          tk_rdata;
    logic          rw_we;
    logic          rw_re;
    logic [PW-1:0] rw_raddr;
    logic [ROW_W-1:0] rw_rdata;
    logic          mod_start;
    logic          mod_done;
    logic [PW-1:0] mod_rem;

    // Effective line count, clamped into 1..MAX_LINES.
    always_comb begin
        if (r_line_count == '0) begin
            n_lines = CW'(1);
        end else if (32'(r_line_count) > 32'(MAX_LINES)) begin
            n_lines = CW'(MAX_LINES);
        end else begin
            n_lines = CW'(r_line_count);
        end
    end

    always_comb begin
        cur1        = CW'(r_cursor) + 1'b1;
        in_acc      = i_in.valid && (r_state == S_IDLE);
        out_free    = !r_o_valid || o_out.ready;
        is_full     = (r_next_row >= n_lines);
        clr_last    = (r_clr_addr == PW'(MAX_LINES - 1));
        probe_free  = r_probe_vld && !tk_rdata;
        probe_hit   = probe_free && (r_skip == SKIP_W'(1));
        walk_inc    = (r_walk_addr == PW'(n_lines - 1'b1)) ? '0 : r_walk_addr + 1'b1;
        gen_sum     = r_gen_first + r_gen_second;
        gen_swap    = {gen_sum[7:0], gen_sum[15:8]};
        skip_init   = (gen_sum[7:0] == '0) ? SKIP_W'(1) : gen_sum[7:0];
        lk_in_range = (32'(i_in.lookup_position) < 32'(MAX_LINES));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (clr_last) begin
                    n_state = r_emit_clr ? S_EMIT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in.op)
                        OP_START:  n_state = S_CLEAR;
                        OP_PLACE: begin
                            if (is_full) begin
                                n_state = S_EMIT;
                            end else if (cur1 >= n_lines) begin
                                n_state = S_MOD;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        OP_LOOKUP: n_state = S_LOOK;
                        default:   n_state = S_EMIT;
                    endcase
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (probe_hit) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: n_state = S_EMIT;
            S_LOOK:  n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Memory controls and handshake outputs.
    always_comb begin
        i_in.ready  = (r_state == S_IDLE);
        i_cfg.ready = 1'b1;
        tk_we       = (r_state == S_CLEAR) || (r_state == S_PLACE);
        tk_waddr    = (r_state == S_PLACE) ? r_place_pos : r_clr_addr;
        tk_wdata    = (r_state == S_PLACE);
        tk_re       = (r_state == S_WALK);
        rw_we       = (r_state == S_PLACE);
        rw_re       = in_acc && (i_in.op == OP_LOOKUP) && lk_in_range;
        rw_raddr    = PW'(i_in.lookup_position);
        mod_start   = in_acc && (i_in.op == OP_PLACE) && !is_full && (cur1 >= n_lines);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_line_count  <= LINE_COUNT_RST;
            r_seed_first  <= SEED_FIRST_RST;
            r_seed_second <= SEED_SECOND_RST;
            r_gen_first   <= SEED_FIRST_RST;
            r_gen_second  <= SEED_SECOND_RST;
            r_cursor      <= '0;
            r_next_row    <= '0;
            r_clr_addr    <= '0;
            r_emit_clr    <= 1'b0;
            r_probe_vld   <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_LINE_COUNT:  r_line_count  <= LINE_CNT_W'(i_cfg.data);
                    REG_SEED_FIRST:  r_seed_first  <= i_cfg.data;
                    REG_SEED_SECOND: r_seed_second <= i_cfg.data;
                    default: ;
                endcase
            end

            if (r_state == S_CLEAR) begin
                r_clr_addr <= clr_last ? '0 : r_clr_addr + 1'b1;
            end

            if (in_acc && i_in.op == OP_START) begin
                r_emit_clr   <= 1'b1;
                r_gen_first  <= r_seed_first;
                r_gen_second <= r_seed_second;
                r_cursor     <= '0;
                r_next_row   <= '0;
            end else if (in_acc && i_in.op == OP_PLACE && !is_full) begin
                r_gen_first  <= gen_swap;
                r_gen_second <= r_gen_first;
            end else if (r_state == S_PLACE) begin
                r_cursor   <= r_place_pos;
                r_next_row <= r_next_row + 1'b1;
            end

            if (r_state == S_CLEAR && clr_last) begin
                r_emit_clr <= 1'b0;
            end

            r_probe_vld <= (r_state == S_WALK) && !probe_hit;

            if (r_state == S_EMIT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res   <= {POS_W'(0), ROW_W'(0), (i_in.op == OP_PLACE) && is_full, 1'b0};
            r_lk_ok <= lk_in_range;
            if (i_in.op == OP_PLACE) begin
                r_skip      <= skip_init;
                r_walk_addr <= PW'(cur1);
            end
        end

        if (r_state == S_MOD && mod_done) begin
            r_walk_addr <= mod_rem;
        end

        // Reads are issued ahead along the cyclic order; each answer comes
        // back in the next cycle, tagged with its address.
        if (r_state == S_WALK) begin
            r_walk_addr  <= walk_inc;
            r_probe_addr <= r_walk_addr;
            if (probe_free) begin
                r_skip <= r_skip - 1'b1;
            end
            if (probe_hit) begin
                r_place_pos <= r_probe_addr;
            end
        end

        if (r_state == S_PLACE) begin
            r_res.placed_position <= POS_W'(r_place_pos);
            r_res.row_value       <= ROW_W'(r_next_row);
            r_res.table_full      <= 1'b0;
            r_res.last_row        <= ((r_next_row + 1'b1) == n_lines);
        end

        if (r_state == S_LOOK) begin
            r_res.row_value <= r_lk_ok ? rw_rdata : '0;
        end

        if (r_state == S_EMIT && out_free) begin
            r_o_res <= r_res;
        end
    end

    lsp_ram #(
        .WIDTH (1),
        .DEPTH (MAX_LINES),
        .AW    (PW)
    ) u_taken_map (
        .i_clk   (i_clk),
        .i_we    (tk_we),
        .i_waddr (tk_waddr),
        .i_wdata (tk_wdata),
        .i_re    (tk_re),
        .i_raddr (r_walk_addr),
        .o_rdata (tk_rdata)
    );

    lsp_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_LINES),
        .AW    (PW)
    ) u_row_table (
        .i_clk   (i_clk),
        .i_we    (rw_we),
        .i_waddr (r_place_pos),
        .i_wdata (ROW_W'(r_next_row)),
        .i_re    (rw_re),
        .i_raddr (rw_raddr),
        .o_rdata (rw_rdata)
    );

    lsp_mod_unit #(
        .CW (CW),
        .PW (PW)
    ) u_mod_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (cur1),
        .i_divisor  (n_lines),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign o_out.valid           = r_o_valid;
    assign o_out.placed_position = r_o_res.placed_position;
    assign o_out.row_value       = r_o_res.row_value;
    assign o_out.table_full      = r_o_res.table_full;
    assign o_out.last_row        = r_o_res.last_row;

    a_walk_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> r_skip != '0)
        else $error("walk running with a zero skip count");

    a_place_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PLACE |=> r_state == S_EMIT && !r_res.table_full)
        else $error("placement did not produce a non-full result");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state) == S_EMIT)
        else $error("result register loaded outside the emit step");

    a_place_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PLACE |-> CW'(r_place_pos) < n_lines)
        else $error("placed position beyond the line count");

endmodule

>>> dv/lsp_permutation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line scramble permutation checker
// Watches the configuration, request and result channels of the permutation
// generator, predicts every result from its own copy of the generator state
// and compares each returned result field by field, in order.
// ----------------------------------------------------------------------------
module lsp_permutation_checker
    import lsp_pkg::*;
#(
    parameter int MAX_LINES = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_end_of_test,
    lsp_cfg_if   i_cfg,
    lsp_in_if    i_req,
    lsp_out_if   i_res,
    output int   o_fail_count
);

    logic [LINE_CNT_W-1:0] line_count_reg;
    logic [GEN_W-1:0]      seed_first_reg;
    logic [GEN_W-1:0]      seed_second_reg;
    logic [GEN_W-1:0]      gen_first;
    logic [GEN_W-1:0]      gen_second;
    logic [ROW_W-1:0]      row_store [MAX_LINES];
    bit                    taken [MAX_LINES];
    int                    cursor_pos;
    int                    rows_placed;
    t_res                  pending_results [$];
    bit                    leftover_checked = 1'b0;
    int                    fails = 0;

    assign o_fail_count = fails;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        fails++;
    endtask

    function automatic int lines_in_use();
        int n;
        n = line_count_reg;
        if (n < 1) n = 1;
        if (n > MAX_LINES) n = MAX_LINES;
        return n;
    endfunction

    task automatic start_run();
        foreach (taken[i]) taken[i] = 1'b0;
        gen_first   = seed_first_reg;
        gen_second  = seed_second_reg;
        cursor_pos  = 0;
        rows_placed = 0;
    endtask

    task automatic compute_permutation_result(input logic [OP_W-1:0] op,
                                              input logic [POS_W-1:0] pos,
                                              output t_res r);
        int n;
        int skip;
        int c;
        logic [GEN_W-1:0] sum;
        r = '0;
        case (op)
            OP_START: begin
                start_run();
            end
            OP_PLACE: begin
                n = lines_in_use();
                if (rows_placed >= n) begin
                    // A full table leaves the generator and the cursor untouched.
                    r.table_full = 1'b1;
                end else begin
                    sum        = gen_first + gen_second;
                    gen_second = gen_first;
                    gen_first  = {sum[7:0], sum[15:8]};
                    skip       = sum[7:0];
                    if (skip == 0) skip = 1;
                    c = cursor_pos;
                    while (skip != 0) begin
                        c = (c + 1) % n;
                        if (!taken[c]) skip--;
                    end
                    cursor_pos        = c;
                    row_store[c]      = ROW_W'(rows_placed);
                    taken[c]          = 1'b1;
                    r.placed_position = POS_W'(c);
                    r.row_value       = ROW_W'(rows_placed);
                    rows_placed++;
                    r.last_row        = (rows_placed == n);
                end
            end
            OP_LOOKUP: begin
                if (pos < MAX_LINES) r.row_value = row_store[pos];
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_res want;
        t_res fresh;
        if (!i_rst_n) begin
            line_count_reg  = LINE_COUNT_RST;
            seed_first_reg  = SEED_FIRST_RST;
            seed_second_reg = SEED_SECOND_RST;
            start_run();
            pending_results.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_LINE_COUNT:  line_count_reg  = i_cfg.data[LINE_CNT_W-1:0];
                    REG_SEED_FIRST:  seed_first_reg  = i_cfg.data;
                    REG_SEED_SECOND: seed_second_reg = i_cfg.data;
                    default: ;
                endcase
            end
            // Results are compared before the new request is predicted, so a
            // result is never matched against the prediction of a request taken alongside it.
            if (i_res.valid && i_res.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no request pending", 0, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_res.placed_position !== want.placed_position)
                        report_mismatch("placed_position", i_res.placed_position,
                                        want.placed_position);
                    if (i_res.row_value !== want.row_value)
                        report_mismatch("row_value", i_res.row_value, want.row_value);
                    if (i_res.table_full !== want.table_full)
                        report_mismatch("table_full", i_res.table_full, want.table_full);
                    if (i_res.last_row !== want.last_row)
                        report_mismatch("last_row", i_res.last_row, want.last_row);
                end
            end
            if (i_req.valid && i_req.ready) begin
                compute_permutation_result(i_req.op, i_req.lookup_position, fresh);
                pending_results.push_back(fresh);
            end
            if (i_end_of_test && !leftover_checked) begin
                leftover_checked = 1'b1;
                if (pending_results.size() != 0)
                    report_mismatch("results never returned", 0,
                                    pending_results.size());
            end
        end
    end

endmodule

>>> dv/line_scramble_permutation_generator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line scramble permutation generator test
// Drives start, place and lookup requests under several line counts and seeds,
// with random gaps on both channels and one long result stall, and lets the
// permutation checker judge every result.
// ----------------------------------------------------------------------------
module line_scramble_permutation_generator_top_test
    import lsp_pkg::*;
();

    localparam int              MAX_LINES        = 1024;
    localparam logic [OP_W-1:0] OP_UNUSED        = 2'd3;
    localparam int              ITEM_TARGET      = 1250;
    localparam int              LONG_HOLD_CYCLES = 400;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic end_of_test = 1'b0;
    int   fail_count;

    lsp_in_if  req_ch ();
    lsp_out_if res_ch ();
    lsp_cfg_if cfg_ch ();

    // Bookkeeping for choosing lookups only of rows that were really written.
    logic [OP_W-1:0] sent_ops [$];
    bit              rows_written [MAX_LINES];
    int              written_positions [$];
    int              sent = 0;
    int              received = 0;
    bit              sender_eager = 1'b0;
    bit              receiver_eager = 1'b0;
    bit              long_hold = 1'b0;

    always #5 i_clk = ~i_clk;

    line_scramble_permutation_generator_top #(
        .MAX_LINES(MAX_LINES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    lsp_permutation_checker #(
        .MAX_LINES(MAX_LINES)
    ) permutation_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_end_of_test (end_of_test),
        .i_cfg         (cfg_ch),
        .i_req         (req_ch),
        .i_res         (res_ch),
        .o_fail_count  (fail_count)
    );

    task automatic send_req(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, 5);
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.op              <= op;
        req_ch.lookup_position <= pos;
        do @(posedge i_clk); while (!req_ch.ready);
        sent_ops.push_back(op);
        sent++;
    endtask

    task automatic lookup_written();
        if (written_positions.size() == 0) begin
            send_req(OP_UNUSED, POS_W'($urandom));
        end else begin
            send_req(OP_LOOKUP, POS_W'(written_positions[
                $urandom_range(0, written_positions.size() - 1)]));
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (received != sent) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [GEN_W-1:0] draw_seed();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return 16'h0000;
        if (pick == 1) return 16'hFFFF;
        return GEN_W'($urandom);
    endfunction

    // One phase: a line count, maybe new seeds, usually a start, then a mix of
    // requests. Large line counts get only a few places, since each place can
    // walk hundreds of positions.
    task automatic run_phase(input int phase_no);
        int kind;
        int line_cfg;
        int place_cap;
        int places;
        int pick;
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            line_cfg  = $urandom_range(1, 16);
            place_cap = 2 * line_cfg + 4;
        end else if (kind <= 8) begin
            line_cfg  = $urandom_range(17, 64);
            place_cap = line_cfg * 3 / 4;
        end else begin
            line_cfg  = ($urandom_range(0, 3) == 0) ? 2047 : $urandom_range(513, 1024);
            place_cap = 12;
        end
        wait_idle();
        cfg_write(REG_LINE_COUNT, CFG_DATA_W'(line_cfg));
        if ($urandom_range(0, 3) == 0) begin
            cfg_write(REG_SEED_FIRST, draw_seed());
            cfg_write(REG_SEED_SECOND, draw_seed());
        end
        sender_eager = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 4) != 0) send_req(OP_START, POS_W'($urandom));
        if (phase_no == 2) long_hold = 1'b1;
        places = 0;
        repeat ($urandom_range(10, 40)) begin
            pick = $urandom_range(0, 99);
            if (pick < 60 && places < place_cap) begin
                send_req(OP_PLACE, POS_W'($urandom));
                places++;
            end else if (pick < 93) begin
                lookup_written();
            end else if (pick < 96) begin
                send_req(OP_START, POS_W'($urandom));
            end else begin
                send_req(OP_UNUSED, POS_W'($urandom));
            end
        end
    endtask

    // Result receiver: random stalls, stretches without stalls, one long hold.
    initial begin
        int gap;
        logic [OP_W-1:0] op;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                long_hold = 1'b0;
            end
            if ($urandom_range(0, 19) == 0) receiver_eager = !receiver_eager;
            gap = receiver_eager ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            op = sent_ops.pop_front();
            if (op == OP_PLACE && !res_ch.table_full &&
                !rows_written[res_ch.placed_position]) begin
                rows_written[res_ch.placed_position] = 1'b1;
                written_positions.push_back(res_ch.placed_position);
            end
            received++;
        end
    end

    initial begin
        int phase_no;
        i_rst_n                = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.op              = OP_START;
        req_ch.lookup_position = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = REG_LINE_COUNT;
        cfg_ch.data            = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: undefined op, a few places over 1024 lines.
        send_req(OP_UNUSED, 10'h3FF);
        repeat (3) send_req(OP_PLACE, POS_W'($urandom));
        wait_idle();
        lookup_written();

        // Single line: the first place is the last row, the next finds it full.
        wait_idle();
        cfg_write(REG_LINE_COUNT, 16'd1);
        send_req(OP_START, 10'h000);
        send_req(OP_PLACE, 10'h155);
        send_req(OP_PLACE, 10'h2AA);
        wait_idle();
        send_req(OP_LOOKUP, 10'h000);

        // Line counts outside the legal range are clamped.
        wait_idle();
        cfg_write(REG_LINE_COUNT, 16'd0);
        send_req(OP_START, 10'h3FF);
        send_req(OP_PLACE, 10'h000);
        wait_idle();
        cfg_write(REG_LINE_COUNT, 16'd2047);
        cfg_write(REG_SEED_FIRST, 16'h0000);
        cfg_write(REG_SEED_SECOND, 16'h0000);
        send_req(OP_START, 10'h000);
        send_req(OP_PLACE, 10'h000);
        send_req(OP_PLACE, 10'h000);

        wait_idle();
        cfg_write(REG_SEED_FIRST, 16'hFFFF);
        cfg_write(REG_SEED_SECOND, 16'hFFFF);
        send_req(OP_START, 10'h000);
        send_req(OP_PLACE, 10'h000);

        // Line count shrunk and then grown without a new start.
        wait_idle();
        cfg_write(REG_LINE_COUNT, 16'd8);
        send_req(OP_START, 10'h000);
        repeat (5) send_req(OP_PLACE, POS_W'($urandom));
        wait_idle();
        cfg_write(REG_LINE_COUNT, 16'd3);
        repeat (2) send_req(OP_PLACE, POS_W'($urandom));
        wait_idle();
        cfg_write(REG_LINE_COUNT, 16'd6);
        repeat (2) send_req(OP_PLACE, POS_W'($urandom));

        phase_no = 0;
        while (sent < ITEM_TARGET) begin
            run_phase(phase_no);
            phase_no++;
        end

        wait_idle();
        end_of_test <= 1'b1;
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("** line_scramble_permutation_generator_top: PASSED **");
        end else begin
            $display("** line_scramble_permutation_generator_top: FAILED **");
        end
        $finish;
    end

    // A correct run ends long before this timeout, which reports the run as failed.
    initial begin
        #200_000_000;
        $display("** line_scramble_permutation_generator_top: FAILED **");
        $finish;
    end

endmodule
